### sv/mtcs_pkg.sv
// shared types and constants of the multiplexed timer scheduler
package mtcs_pkg;

  typedef enum logic [2:0] {
    MODE_ALLOC   = 3'd0,
    MODE_FREE    = 3'd1,
    MODE_START   = 3'd2,
    MODE_STOP    = 3'd3,
    MODE_QUERY   = 3'd4,
    MODE_ELAPSED = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ALL_USED    = 3'd1,
    ST_ILLEGAL_ID  = 3'd2,
    ST_NOT_ALLOC   = 3'd3,
    ST_NOT_RUNNING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_CLOCK_HZ   = 2'd0,
    CFG_PRESCALE   = 2'd1,
    CFG_TICK_ADJ   = 2'd2,
    CFG_MAX_CMP    = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_TU_DIV,
    S_M2T,
    S_M2T_DIV,
    S_ST_MUL,
    S_ST_WR,
    S_ADV_RD,
    S_ADV_S1,
    S_ADV_S2,
    S_RESCHED,
    S_Q_SUB,
    S_Q_MUL0,
    S_Q_MUL1,
    S_Q_ADD,
    S_Q_DIV,
    S_FIRE0,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FINAL
  } state_e;

  localparam int MsPerSec   = 1000;
  localparam int HalfMs     = 500;
  localparam int UsPerSec   = 1000000;

  localparam logic [19:0] ClockHzRst  = 20'd32768;
  localparam logic [15:0] PrescaleRst = 16'd1;
  localparam logic [31:0] MaxCmpRst   = 32'd16777115;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic        fired;
    logic        is_running;
    logic [31:0] remaining_ms;
    logic [31:0] next_interval;
    logic        schedule_active;
    logic        last;
  } result_t;

endpackage

### sv/mtcs_div.sv
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor
module mtcs_div import mtcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem_q, quo_q[63]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### sv/mtcs_mem.sv
// per-slot tick and drift memory, one write and one registered read port
module mtcs_mem import mtcs_pkg::*; #(
  parameter int NUM_TIMERS = 8,
  parameter int WORD_W     = 144
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] waddr_i,
  input  logic [WORD_W-1:0]     wdata_i,
  input  logic                  re_i,
  input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] raddr_i,
  output logic [WORD_W-1:0]     rdata_o
);

  logic [WORD_W-1:0] mem_q [NUM_TIMERS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/multi_timer_compare_scheduler_core.sv
// top level: slot sequencer for the timer table sharing one compare
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o | mode, tmr_sel, periodic, timeout_ms,
//          |           |                         | has_callback, elapsed_ticks
//  out     | output    | out_valid_o/out_ready_i | status, slot, fired, is_running,
//          |           |                         | remaining_ms, next_interval, schedule_active, last
//  cfg     | input     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// one item at a time; the 64-step divider sets most of the latency
// elapsed or start: tick period divide (plus the ms-to-tick divide on start), then
// an update pass reading and writing back each running slot (armed start and elapsed only)
// and a minimum scan reading each running slot
// query: slot read, multiply, round and divide, then the scan; allocate, free, stop: the scan
// reset clears control and flags; slot memory holds nothing valid until a start
// out stall freezes the sequencer only when a result has to be written
module multi_timer_compare_scheduler_core import mtcs_pkg::*; #(
  parameter int NUM_TIMERS = 8,
  parameter int TICK_WIDTH = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  tmr_sel_i,
  input  logic        periodic_i,
  input  logic [31:0] timeout_ms_i,
  input  logic        has_callback_i,
  input  logic [31:0] elapsed_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic        fired_o,
  output logic        is_running_o,
  output logic [31:0] remaining_ms_o,
  output logic [31:0] next_interval_o,
  output logic        schedule_active_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int IdxW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CntW  = $clog2(NUM_TIMERS + 1);
  localparam int TW    = TICK_WIDTH;
  localparam int WordW = 2 * TICK_WIDTH + 64;
  localparam logic [63:0] TickMax = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TICK_WIDTH);

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
    logic [TW-1:0] r;
    r = (v == '1) ? v : v + 1'b1;
    return r;
  endfunction

  // configuration
  logic [19:0] clk_hz_q;
  logic [15:0] prescale_q;
  logic [1:0]  adjust_q;
  logic [31:0] max_cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q   <= ClockHzRst;
      prescale_q <= PrescaleRst;
      adjust_q   <= '0;
      max_cmp_q  <= MaxCmpRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLOCK_HZ: clk_hz_q   <= cfg_data_i[19:0];
        CFG_PRESCALE: prescale_q <= cfg_data_i[15:0];
        CFG_TICK_ADJ: adjust_q   <= cfg_data_i[1:0];
        CFG_MAX_CMP:  max_cmp_q  <= cfg_data_i;
        default:      clk_hz_q   <= clk_hz_q;
      endcase
    end
  end

  logic [19:0] clk_eff;
  logic [15:0] pre_eff;
  logic [24:0] pre_ms;
  logic [24:0] pre_half;
  logic [35:0] us_num;

  assign clk_eff  = (clk_hz_q == '0) ? 20'd1 : clk_hz_q;
  assign pre_eff  = (prescale_q == '0) ? 16'd1 : prescale_q;
  assign pre_ms   = 25'(pre_eff) * 25'(MsPerSec);
  assign pre_half = 25'(pre_eff) * 25'(HalfMs);
  assign us_num   = 36'(pre_eff) * 36'(UsPerSec);

  // sequencer state
  state_e          state_q, state_d;
  logic [2:0]      mode_q, mode_d;
  logic [3:0]      tid_q, tid_d;
  logic            per_q, per_d;
  logic [31:0]     tms_q, tms_d;
  logic            cb_q, cb_d;
  logic [31:0]     el_q, el_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic [2:0]      st_q, st_d;
  logic [3:0]      slot_q, slot_d;
  logic            ok_q, ok_d;
  logic [31:0]     rem_q, rem_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            any_q, any_d;
  logic [TW-1:0]   min_q, min_d;
  logic [35:0]     tu_q, tu_d;
  logic [TW-1:0]   t_q, t_d;
  logic [31:0]     tprod_q, tprod_d;
  logic [63:0]     q64_q, q64_d;
  logic [95:0]     prod_q, prod_d;
  logic [TW-1:0]   nl_q, nl_d;
  logic [31:0]     nd_q, nd_d;
  logic            exp_q, exp_d;
  logic            add_q, add_d;

  logic [NUM_TIMERS-1:0] taken_q, taken_d, running_q, running_d;
  logic [NUM_TIMERS-1:0] periodic_q, periodic_d, notify_q, notify_d;
  logic                  armed_q, armed_d;

  logic    out_valid_q;
  result_t out_q;
  logic    out_free;
  logic    emit;
  result_t ev;

  // memory and divider hookup
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [WordW-1:0]  mem_wdata, mem_rdata;
  logic              div_start, div_done;
  logic [63:0]       div_n, div_q;
  logic [31:0]       div_d;

  mtcs_mem #(
    .NUM_TIMERS (NUM_TIMERS),
    .WORD_W     (WordW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mtcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  logic [TW-1:0]   rd_reload, rd_left;
  logic [31:0]     rd_comp, rd_drift;
  logic [TW-1:0]   el_t;
  logic [IdxW-1:0] idx_w;
  logic            idx_end;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic [52:0]     m2t_num;
  logic [31:0]     mul_a;
  logic [56:0]     mul_p;
  logic [95:0]     q_sum;
  logic [TW-1:0]   adj_t, st_reload, over_t, nl_adj, q_t;
  logic [31:0]     nd_adj;

  assign rd_reload = mem_rdata[WordW-1 -: TW];
  assign rd_left   = mem_rdata[TW+63 -: TW];
  assign rd_comp   = mem_rdata[63:32];
  assign rd_drift  = mem_rdata[31:0];
  assign el_t      = TW'(el_q);
  assign idx_w     = idx_q[IdxW-1:0];
  assign idx_end   = (idx_q == CntW'(NUM_TIMERS));
  assign out_free  = !out_valid_q || out_ready_i;
  assign m2t_num   = 53'(tms_q) * 53'(clk_eff) + 53'(pre_half);
  assign mul_a     = (state_q == S_Q_MUL1) ? q64_q[63:32] : q64_q[31:0];
  assign mul_p     = 57'(mul_a) * 57'(pre_ms);
  assign q_sum     = prod_q + 96'(clk_eff[19:1]);
  assign adj_t     = (t_q > TW'(adjust_q)) ? t_q - TW'(adjust_q) : '0;
  assign st_reload = per_q ? t_q : adj_t;
  assign over_t    = el_t - rd_left;
  assign q_t       = (rd_left > el_t) ? rd_left - el_t : '0;

  // first free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!taken_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // drift correction of one tick after a periodic reload
  always_comb begin
    nl_adj = nl_q;
    nd_adj = nd_q;
    if (exp_q && periodic_q[idx_w] && ({4'b0, nd_q} >= tu_q)) begin
      nl_adj = add_q ? sat_inc(nl_q) : ((nl_q != '0) ? nl_q - 1'b1 : nl_q);
      nd_adj = nd_q - tu_q[31:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    tid_d      = tid_q;
    per_d      = per_q;
    tms_d      = tms_q;
    cb_d       = cb_q;
    el_d       = el_q;
    ridx_d     = ridx_q;
    st_d       = st_q;
    slot_d     = slot_q;
    ok_d       = ok_q;
    rem_d      = rem_q;
    idx_d      = idx_q;
    any_d      = any_q;
    min_d      = min_q;
    tu_d       = tu_q;
    t_d        = t_q;
    tprod_d    = tprod_q;
    q64_d      = q64_q;
    prod_d     = prod_q;
    nl_d       = nl_q;
    nd_d       = nd_q;
    exp_d      = exp_q;
    add_d      = add_q;
    taken_d    = taken_q;
    running_d  = running_q;
    periodic_d = periodic_q;
    notify_d   = notify_q;
    armed_d    = armed_q;
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = ridx_q;
    mem_raddr  = idx_w;
    mem_wdata  = {st_reload, sat_inc(st_reload), 32'(tms_q * 32'(MsPerSec)) - tprod_q,
                  tu_q[32:1]};
    div_start  = 1'b0;
    div_n      = 64'(us_num);
    div_d      = 32'(clk_eff);
    emit       = 1'b0;
    ev         = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d  = mode_i;
          tid_d   = tmr_sel_i;
          per_d   = periodic_i;
          tms_d   = timeout_ms_i;
          cb_d    = has_callback_i;
          el_d    = elapsed_ticks_i;
          ridx_d  = IdxW'(tmr_sel_i);
          slot_d  = tmr_sel_i;
          ok_d    = (int'(tmr_sel_i) < NUM_TIMERS);
          st_d    = ST_OK;
          rem_d   = '0;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        idx_d   = '0;
        any_d   = 1'b0;
        state_d = S_SCAN_RD;
        case (mode_q)
          MODE_ALLOC: begin
            if (free_found) begin
              taken_d[free_idx] = 1'b1;
              ridx_d = free_idx;
              slot_d = 4'(free_idx);
              ok_d   = 1'b1;
            end else begin
              st_d   = ST_ALL_USED;
              slot_d = '0;
              ok_d   = 1'b0;
            end
          end
          MODE_FREE, MODE_START, MODE_STOP, MODE_QUERY: begin
            if (!ok_q) begin
              st_d = ST_ILLEGAL_ID;
            end else if (mode_q == MODE_FREE) begin
              running_d[ridx_q] = 1'b0;
              taken_d[ridx_q]   = 1'b0;
            end else if (!taken_q[ridx_q]) begin
              st_d = ST_NOT_ALLOC;
            end else if (mode_q == MODE_STOP) begin
              running_d[ridx_q] = 1'b0;
            end else if (mode_q == MODE_QUERY) begin
              if (!running_q[ridx_q]) begin
                st_d = ST_NOT_RUNNING;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ridx_q;
                state_d   = S_Q_SUB;
              end
            end else if (tms_q == '0) begin
              if (cb_q) begin
                state_d = S_FIRE0;
              end
            end else begin
              div_start = 1'b1;
              state_d   = S_TU_DIV;
            end
          end
          MODE_ELAPSED: begin
            slot_d    = '0;
            ok_d      = 1'b0;
            div_start = 1'b1;
            state_d   = S_TU_DIV;
          end
          default: begin
            state_d = S_SCAN_RD;
          end
        endcase
      end

      // tick period in microseconds
      S_TU_DIV: begin
        if (div_done) begin
          tu_d    = div_q[35:0];
          idx_d   = '0;
          state_d = (mode_q == MODE_START) ? S_M2T : S_ADV_RD;
        end
      end

      S_M2T: begin
        div_start = 1'b1;
        div_n     = 64'(m2t_num);
        div_d     = 32'(pre_ms);
        state_d   = S_M2T_DIV;
      end

      S_M2T_DIV: begin
        if (div_done) begin
          t_d     = (div_q > TickMax) ? TW'(TickMax) : TW'(div_q);
          state_d = S_ST_MUL;
        end
      end

      S_ST_MUL: begin
        tprod_d = t_q[31:0] * tu_q[31:0];
        state_d = S_ST_WR;
      end

      S_ST_WR: begin
        mem_we             = 1'b1;
        notify_d[ridx_q]   = cb_q;
        periodic_d[ridx_q] = per_q;
        idx_d              = '0;
        any_d              = 1'b0;
        if (!armed_q) begin
          running_d[ridx_q] = 1'b1;
          armed_d           = 1'b1;
          state_d           = S_SCAN_RD;
        end else begin
          running_d[ridx_q] = 1'b0;
          state_d           = S_ADV_RD;
        end
      end

      S_ADV_RD: begin
        if (idx_end) begin
          state_d = S_RESCHED;
        end else if (running_q[idx_w]) begin
          mem_re  = 1'b1;
          state_d = S_ADV_S1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_ADV_S1: begin
        add_d = (rd_comp != '0) && !rd_comp[31];
        nd_d  = rd_drift;
        if (rd_left > el_t) begin
          exp_d = 1'b0;
          nl_d  = rd_left - el_t;
        end else begin
          exp_d = 1'b1;
          if (periodic_q[idx_w]) begin
            nl_d = (rd_reload > over_t) ? rd_reload - over_t : '0;
            nd_d = ((rd_comp != '0) && !rd_comp[31]) ? rd_drift + rd_comp
                                                    : rd_drift - rd_comp;
          end else begin
            nl_d = rd_left;
          end
        end
        state_d = S_ADV_S2;
      end

      S_ADV_S2: begin
        if (!(exp_q && notify_q[idx_w]) || out_free) begin
          mem_we    = 1'b1;
          mem_waddr = idx_w;
          mem_wdata = {rd_reload, nl_adj, rd_comp, nd_adj};
          if (exp_q && !periodic_q[idx_w]) begin
            running_d[idx_w] = 1'b0;
          end
          if (exp_q && notify_q[idx_w]) begin
            emit          = 1'b1;
            ev.status     = ST_OK;
            ev.slot       = 4'(idx_w);
            ev.fired      = 1'b1;
            ev.is_running = periodic_q[idx_w];
          end
          idx_d   = idx_q + 1'b1;
          state_d = S_ADV_RD;
        end
      end

      S_RESCHED: begin
        if (mode_q == MODE_START) begin
          running_d[ridx_q] = 1'b1;
        end
        armed_d = |running_d;
        idx_d   = '0;
        any_d   = 1'b0;
        state_d = S_SCAN_RD;
      end

      S_Q_SUB: begin
        q64_d   = 64'(q_t);
        state_d = S_Q_MUL0;
      end

      S_Q_MUL0: begin
        prod_d  = 96'(mul_p);
        state_d = S_Q_MUL1;
      end

      S_Q_MUL1: begin
        prod_d  = prod_q + {7'b0, mul_p, 32'b0};
        state_d = S_Q_ADD;
      end

      S_Q_ADD: begin
        if (q_sum[95:64] != '0) begin
          rem_d   = '1;
          state_d = S_SCAN_RD;
        end else begin
          div_start = 1'b1;
          div_n     = q_sum[63:0];
          state_d   = S_Q_DIV;
        end
      end

      S_Q_DIV: begin
        if (div_done) begin
          rem_d   = (div_q[63:32] != '0) ? '1 : div_q[31:0];
          state_d = S_SCAN_RD;
        end
      end

      // zero timeout with a callback fires at once
      S_FIRE0: begin
        if (out_free) begin
          emit          = 1'b1;
          ev.status     = ST_OK;
          ev.slot       = tid_q;
          ev.fired      = 1'b1;
          ev.is_running = running_q[ridx_q];
          state_d       = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        if (idx_end) begin
          state_d = S_FINAL;
        end else if (running_q[idx_w]) begin
          mem_re  = 1'b1;
          state_d = S_SCAN_CMP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_SCAN_CMP: begin
        if (!any_q || (rd_left < min_q)) begin
          min_d = rd_left;
          any_d = 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_SCAN_RD;
      end

      S_FINAL: begin
        if (out_free) begin
          emit               = 1'b1;
          ev.status          = st_q;
          ev.slot            = slot_q;
          ev.fired           = 1'b0;
          ev.is_running      = ok_q && running_q[ridx_q];
          ev.remaining_ms    = rem_q;
          ev.next_interval   = !any_q ? '0 :
                               ((min_q > TW'(max_cmp_q)) ? max_cmp_q : min_q[31:0]);
          ev.schedule_active = armed_q;
          ev.last            = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      any_q       <= 1'b0;
      taken_q     <= '0;
      running_q   <= '0;
      periodic_q  <= '0;
      notify_q    <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      any_q      <= any_d;
      taken_q    <= taken_d;
      running_q  <= running_d;
      periodic_q <= periodic_d;
      notify_q   <= notify_d;
      armed_q    <= armed_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    tid_q   <= tid_d;
    per_q   <= per_d;
    tms_q   <= tms_d;
    cb_q    <= cb_d;
    el_q    <= el_d;
    ridx_q  <= ridx_d;
    st_q    <= st_d;
    slot_q  <= slot_d;
    ok_q    <= ok_d;
    rem_q   <= rem_d;
    min_q   <= min_d;
    tu_q    <= tu_d;
    t_q     <= t_d;
    tprod_q <= tprod_d;
    q64_q   <= q64_d;
    prod_q  <= prod_d;
    nl_q    <= nl_d;
    nd_q    <= nd_d;
    exp_q   <= exp_d;
    add_q   <= add_d;
    if (emit) begin
      out_q <= ev;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign slot_o            = out_q.slot;
  assign fired_o           = out_q.fired;
  assign is_running_o      = out_q.is_running;
  assign remaining_ms_o    = out_q.remaining_ms;
  assign next_interval_o   = out_q.next_interval;
  assign schedule_active_o = out_q.schedule_active;
  assign last_o            = out_q.last;

endmodule
